>>> rtl/bssim_pkg.sv
// Shared types and constants of the block SSIM engine.
// No dependencies; every other file but bssim_fifo imports this package.
package bssim_pkg;

	localparam int SCORE_W = 18;
	localparam int TOTAL_W = 38;
	localparam int RES_W   = 2 * SCORE_W + 1;
	localparam int FRAC_W  = 8;
	localparam int STAB_W  = 24;
	localparam int SIDE_REG_W = 5;
	localparam int INDEX_W = 2;

	localparam int DIV_NW = 38;
	localparam int DIV_DW = 32;
	localparam int DIV_CW = 6;
	localparam int RATIO_BITS = 16;

	localparam logic [16:0] ONE_Q16 = 17'h10000;

	localparam logic [INDEX_W-1:0] REG_BLOCK_SIDE = 2'd0;
	localparam logic [INDEX_W-1:0] REG_LUMA_STAB  = 2'd1;
	localparam logic [INDEX_W-1:0] REG_CONTR_STAB = 2'd2;

	localparam logic [SIDE_REG_W-1:0] SIDE_RESET = 5'd8;
	localparam logic [STAB_W-1:0] LUMA_RESET   = 24'd1665;
	localparam logic [STAB_W-1:0] CONTR_RESET  = 24'd14982;

	typedef struct packed {
		logic              start;
		logic [DIV_NW-1:0] num;
		logic [DIV_DW-1:0] den;
		logic [DIV_DW-1:0] rem;
		logic [DIV_CW-1:0] steps;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [DIV_NW-1:0] quo;
	} div_rsp_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DIV_MX,
		B_DIV_MY,
		B_DIV_EXX,
		B_DIV_EYY,
		B_DIV_EXY,
		B_MUL,
		B_PREP,
		B_RATIO1,
		B_RATIO2,
		B_PROD,
		B_ACC,
		B_MEAN,
		B_OUT
	} back_state_t;

endpackage

>>> rtl/block_ssim_engine_unit.sv
// Channel   | Ports                                      | Beat
// pixels in | push, full, src_pixel, cmp_pixel, final_block | push && !full
// results   | pop, empty, block_score, image_score, image_done | pop && !empty
// config    | wr_en, wr_index, wr_data                   | wr_en
//
// A pixel beat is taken every cycle while the two-block snapshot queue has room.
// Each block is scored by the back end through the one-bit-per-cycle shared divider,
// with one more division on the image's last block for the image mean. Blocks that
// arrive faster than they are scored fill the snapshot queue and raise full until
// it drains.
// Reset is immediate; there is no clearing pass. A held result does not block
// scoring of the next block until the two-entry result queue is full.
// Top level of the block SSIM engine; depends on bssim_pkg and all bssim modules.
module block_ssim_engine_unit #(
	parameter int MAX_BLOCK_SIDE = 16,
	parameter int BLOCK_COUNT_BITS = 20
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                push,
	output logic                                full,
	input  logic [7:0]                          src_pixel,
	input  logic [7:0]                          cmp_pixel,
	input  logic                                final_block,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [bssim_pkg::SCORE_W-1:0] block_score,
	output logic signed [bssim_pkg::SCORE_W-1:0] image_score,
	output logic                                image_done,
	input  logic                                wr_en,
	input  logic [bssim_pkg::INDEX_W-1:0]       wr_index,
	input  logic [bssim_pkg::STAB_W-1:0]        wr_data
);
	import bssim_pkg::*;

	localparam int CW = $clog2(MAX_BLOCK_SIDE * MAX_BLOCK_SIDE + 1);
	localparam int SW = 8 + CW;
	localparam int QW = 16 + CW;
	localparam int SNAP_W = 1 + CW + 2 * SW + 3 * QW;

	logic [SIDE_REG_W-1:0] side_q;
	logic [STAB_W-1:0]     c1_q, c2_q;
	logic                  take;
	logic                  snap_push, snap_pop, snap_full, snap_empty;
	logic [SNAP_W-1:0]     snap_wdata, snap_rdata;
	logic                  res_push, res_full;
	logic [RES_W-1:0]      res_wdata, res_rdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_q <= SIDE_RESET;
			c1_q   <= LUMA_RESET;
			c2_q   <= CONTR_RESET;
		end else if (wr_en) begin
			case (wr_index)
				REG_BLOCK_SIDE: side_q <= wr_data[SIDE_REG_W-1:0];
				REG_LUMA_STAB:  c1_q   <= wr_data;
				REG_CONTR_STAB: c2_q   <= wr_data;
				default: begin
				end
			endcase
		end
	end

	assign full = snap_full;
	assign take = push && !snap_full;

	bssim_front #(
		.MAX_BLOCK_SIDE (MAX_BLOCK_SIDE),
		.CW             (CW),
		.SW             (SW),
		.QW             (QW),
		.SNAP_W         (SNAP_W)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (take),
		.src_pixel   (src_pixel),
		.cmp_pixel   (cmp_pixel),
		.final_block (final_block),
		.side_cfg    (side_q),
		.snap_push   (snap_push),
		.snap_data   (snap_wdata)
	);

	bssim_fifo #(.W(SNAP_W)) u_snap_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (snap_push),
		.wdata  (snap_wdata),
		.rd     (snap_pop),
		.rdata  (snap_rdata),
		.full   (snap_full),
		.empty  (snap_empty)
	);

	bssim_back #(
		.CW               (CW),
		.SW               (SW),
		.QW               (QW),
		.SNAP_W           (SNAP_W),
		.BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.c1         (c1_q),
		.c2         (c2_q),
		.snap_empty (snap_empty),
		.snap_data  (snap_rdata),
		.snap_pop   (snap_pop),
		.res_full   (res_full),
		.res_push   (res_push),
		.res_data   (res_wdata)
	);

	bssim_fifo #(.W(RES_W)) u_res_q (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (res_push),
		.wdata  (res_wdata),
		.rd     (pop),
		.rdata  (res_rdata),
		.full   (res_full),
		.empty  (empty)
	);

	assign block_score = res_rdata[RES_W-1:SCORE_W+1];
	assign image_score = res_rdata[SCORE_W:1];
	assign image_done  = res_rdata[0];

`ifndef NO_ASSERTIONS
	a_snap_room: assert property (@(posedge clk) disable iff (!arst_n)
		snap_push |-> !snap_full)
		else $error("block snapshot dropped on full queue");

	a_res_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> !res_full)
		else $error("result dropped on full queue");

	a_img_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !image_done) |-> (image_score == '0))
		else $error("image score set on a block that does not end the image");
`endif
endmodule

>>> rtl/bssim_fifo.sv
// Two-entry first-word-fall-through queue for block snapshots and results.
// No package dependency.
module bssim_fifo #(
	parameter int W = 8
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         rd,
	output logic [W-1:0] rdata,
	output logic         full,
	output logic         empty
);
	logic [W-1:0] mem_q [2];
	logic         wptr_q;
	logic         rptr_q;
	logic [1:0]   cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign rdata = mem_q[rptr_q];

	always_ff @(posedge clk) begin
		if (wr && !full) begin
			mem_q[wptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= 1'b0;
			rptr_q <= 1'b0;
			cnt_q  <= 2'd0;
		end else begin
			if (wr && !full) begin
				wptr_q <= ~wptr_q;
			end
			if (rd && !empty) begin
				rptr_q <= ~rptr_q;
			end
			case ({wr && !full, rd && !empty})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

>>> rtl/bssim_front.sv
// Front end: accumulates per-block pixel sums and emits a snapshot at block end.
// Depends on bssim_pkg.
module bssim_front #(
	parameter int MAX_BLOCK_SIDE = 16,
	parameter int CW = 9,
	parameter int SW = 17,
	parameter int QW = 25,
	parameter int SNAP_W = 1 + CW + 2 * SW + 3 * QW
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                take,
	input  logic [7:0]                          src_pixel,
	input  logic [7:0]                          cmp_pixel,
	input  logic                                final_block,
	input  logic [bssim_pkg::SIDE_REG_W-1:0]    side_cfg,
	output logic                                snap_push,
	output logic [SNAP_W-1:0]                   snap_data
);
	import bssim_pkg::*;

	localparam int SIDE_W = $clog2(MAX_BLOCK_SIDE + 1);
	localparam int CMP_W  = (SIDE_W > SIDE_REG_W) ? SIDE_W : SIDE_REG_W;

	logic [CMP_W-1:0]    side_wide;
	logic [SIDE_W-1:0]   side_eff;
	logic [2*SIDE_W-1:0] sq_full;
	logic [CW-1:0]       side_sq;
	logic [CW-1:0]       count_q, count_nx;
	logic [SW-1:0]       sum_src_q, sum_cmp_q, sum_src_nx, sum_cmp_nx;
	logic [QW-1:0]       sq_src_q, sq_cmp_q, cross_q, sq_src_nx, sq_cmp_nx, cross_nx;
	logic [15:0]         xx, yy, xy;
	logic                block_end;

	always_comb begin
		side_wide = CMP_W'(side_cfg);
		if (side_wide < CMP_W'(2)) begin
			side_eff = SIDE_W'(2);
		end else if (side_wide > CMP_W'(MAX_BLOCK_SIDE)) begin
			side_eff = SIDE_W'(MAX_BLOCK_SIDE);
		end else begin
			side_eff = SIDE_W'(side_wide);
		end
	end

	assign sq_full = side_eff * side_eff;
	assign side_sq = CW'(sq_full);

	assign xx = src_pixel * src_pixel;
	assign yy = cmp_pixel * cmp_pixel;
	assign xy = src_pixel * cmp_pixel;

	assign count_nx   = count_q + CW'(1);
	assign sum_src_nx = sum_src_q + SW'(src_pixel);
	assign sum_cmp_nx = sum_cmp_q + SW'(cmp_pixel);
	assign sq_src_nx  = sq_src_q + QW'(xx);
	assign sq_cmp_nx  = sq_cmp_q + QW'(yy);
	assign cross_nx   = cross_q + QW'(xy);

	assign block_end = take && (count_nx >= side_sq);
	assign snap_push = block_end;
	assign snap_data = {final_block, count_nx, sum_src_nx, sum_cmp_nx,
		sq_src_nx, sq_cmp_nx, cross_nx};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			sum_src_q <= '0;
			sum_cmp_q <= '0;
			sq_src_q  <= '0;
			sq_cmp_q  <= '0;
			cross_q   <= '0;
		end else if (take) begin
			if (block_end) begin
				// restart sums for the next block
				count_q   <= '0;
				sum_src_q <= '0;
				sum_cmp_q <= '0;
				sq_src_q  <= '0;
				sq_cmp_q  <= '0;
				cross_q   <= '0;
			end else begin
				count_q   <= count_nx;
				sum_src_q <= sum_src_nx;
				sum_cmp_q <= sum_cmp_nx;
				sq_src_q  <= sq_src_nx;
				sq_cmp_q  <= sq_cmp_nx;
				cross_q   <= cross_nx;
			end
		end
	end
endmodule

>>> rtl/bssim_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on bssim_pkg for the request and response types.
module bssim_div (
	input  logic                  clk,
	input  logic                  arst_n,
	input  bssim_pkg::div_req_t   req,
	output bssim_pkg::div_rsp_t   rsp
);
	import bssim_pkg::*;

	logic              busy_q, done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_DW-1:0] rem_q, den_q, rem_nx;
	logic [DIV_NW-1:0] quo_q;
	logic [DIV_DW:0]   shifted;
	logic [DIV_DW+1:0] diff;
	logic              ge;

	assign shifted = {rem_q, quo_q[DIV_NW-1]};
	assign diff    = {1'b0, shifted} - {2'b0, den_q};
	assign ge      = ~diff[DIV_DW+1];
	assign rem_nx  = ge ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CW'(1);
				if (cnt_q == DIV_CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= req.rem;
			quo_q <= req.num;
			den_q <= req.den;
		end else if (busy_q) begin
			rem_q <= rem_nx;
			quo_q <= {quo_q[DIV_NW-2:0], ge};
		end
	end
endmodule

>>> rtl/bssim_back.sv
// Back end: turns a block snapshot into the block score and the image mean.
// Depends on bssim_pkg and bssim_div.
module bssim_back #(
	parameter int CW = 9,
	parameter int SW = 17,
	parameter int QW = 25,
	parameter int SNAP_W = 1 + CW + 2 * SW + 3 * QW,
	parameter int BLOCK_COUNT_BITS = 20
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [bssim_pkg::STAB_W-1:0]     c1,
	input  logic [bssim_pkg::STAB_W-1:0]     c2,
	input  logic                             snap_empty,
	input  logic [SNAP_W-1:0]                snap_data,
	output logic                             snap_pop,
	input  logic                             res_full,
	output logic                             res_push,
	output logic [bssim_pkg::RES_W-1:0]      res_data
);
	import bssim_pkg::*;

	localparam int K_MEAN = SW + FRAC_W;
	localparam int K_MOM  = QW + FRAC_W;

	back_state_t state_q, state_d;
	logic        pend_q, pend_d;
	div_req_t    req;
	div_rsp_t    rsp;

	logic          last_q;
	logic [CW-1:0] n_q;
	logic [SW-1:0] ssrc_q, scmp_q;
	logic [QW-1:0] qsrc_q, qcmp_q, qx_q;

	logic [15:0] mx_q, my_q;
	logic [23:0] exx_q, eyy_q, exy_q;
	logic [31:0] pxx_q, pyy_q, pxy_q;
	logic [25:0] num1_q, den1_q, den2_q;
	logic [26:0] num2mag_q;
	logic        num2neg_q;
	logic [16:0] r1_q, r2_q, mag_q;
	logic        r2neg_q, neg_q;
	logic [SCORE_W-1:0] score_q, img_q;
	logic [TOTAL_W-1:0] total_q, tot_mag_q, total_nx;
	logic               tot_neg_q;
	logic [BLOCK_COUNT_BITS-1:0] tally_q, tally_nx;

	logic [24:0] vx_d, vy_d, cv;
	logic [23:0] vx, vy;
	logic [32:0] sq_sum;
	logic [25:0] num1_d, den1_d, den2_d;
	logic [26:0] num2_d, num2mag_d;
	logic        skip1, skip2;
	logic [33:0] prod, rounded;

	bssim_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	// moment and ratio terms
	assign vx_d   = {1'b0, exx_q} - {1'b0, pxx_q[31:8]};
	assign vy_d   = {1'b0, eyy_q} - {1'b0, pyy_q[31:8]};
	assign vx     = vx_d[24] ? '0 : vx_d[23:0];
	assign vy     = vy_d[24] ? '0 : vy_d[23:0];
	assign cv     = {1'b0, exy_q} - {1'b0, pxy_q[31:8]};
	assign sq_sum = {1'b0, pxx_q} + {1'b0, pyy_q};
	assign num1_d = {1'b0, pxy_q[31:7]} + {2'b0, c1};
	assign den1_d = {1'b0, sq_sum[32:8]} + {2'b0, c1};
	assign num2_d = {cv[24], cv, 1'b0} + {3'b0, c2};
	assign num2mag_d = num2_d[26] ? (27'd0 - num2_d) : num2_d;
	assign den2_d = {2'b0, vx} + {2'b0, vy} + {2'b0, c2};

	assign skip1 = (den1_q == '0) || (num1_q >= den1_q);
	assign skip2 = (den2_q == '0) || (num2mag_q >= {1'b0, den2_q});

	assign prod    = r1_q * r2_q;
	assign rounded = prod + 34'd32768;

	assign total_nx = neg_q ? (total_q - TOTAL_W'(mag_q)) : (total_q + TOTAL_W'(mag_q));
	assign tally_nx = tally_q + BLOCK_COUNT_BITS'(1);

	assign res_data = {score_q, img_q, last_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			pend_q  <= pend_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pend_d   = pend_q;
		req      = '0;
		snap_pop = 1'b0;
		res_push = 1'b0;
		case (state_q)
			B_IDLE: begin
				if (!snap_empty) begin
					snap_pop = 1'b1;
					state_d  = B_DIV_MX;
				end
			end
			B_DIV_MX, B_DIV_MY, B_DIV_EXX, B_DIV_EYY, B_DIV_EXY,
			B_RATIO1, B_RATIO2, B_MEAN: begin
				req.den = DIV_DW'(n_q);
				case (state_q)
					B_DIV_MX: begin
						req.num   = DIV_NW'({ssrc_q, 8'd0}) << (DIV_NW - K_MEAN);
						req.steps = DIV_CW'(K_MEAN);
					end
					B_DIV_MY: begin
						req.num   = DIV_NW'({scmp_q, 8'd0}) << (DIV_NW - K_MEAN);
						req.steps = DIV_CW'(K_MEAN);
					end
					B_DIV_EXX: begin
						req.num   = DIV_NW'({qsrc_q, 8'd0}) << (DIV_NW - K_MOM);
						req.steps = DIV_CW'(K_MOM);
					end
					B_DIV_EYY: begin
						req.num   = DIV_NW'({qcmp_q, 8'd0}) << (DIV_NW - K_MOM);
						req.steps = DIV_CW'(K_MOM);
					end
					B_DIV_EXY: begin
						req.num   = DIV_NW'({qx_q, 8'd0}) << (DIV_NW - K_MOM);
						req.steps = DIV_CW'(K_MOM);
					end
					B_RATIO1: begin
						req.rem   = DIV_DW'(num1_q);
						req.den   = DIV_DW'(den1_q);
						req.steps = DIV_CW'(RATIO_BITS);
					end
					B_RATIO2: begin
						req.rem   = DIV_DW'(num2mag_q);
						req.den   = DIV_DW'(den2_q);
						req.steps = DIV_CW'(RATIO_BITS);
					end
					default: begin
						req.num   = DIV_NW'(tot_mag_q);
						req.den   = DIV_DW'(tally_q);
						req.steps = DIV_CW'(TOTAL_W);
					end
				endcase
				if ((state_q == B_RATIO1 && skip1) || (state_q == B_RATIO2 && skip2)
					|| (state_q == B_MEAN && tally_q == '0)) begin
					state_d = (state_q == B_RATIO1) ? B_RATIO2 :
						(state_q == B_RATIO2) ? B_PROD : B_OUT;
				end else if (!pend_q) begin
					req.start = 1'b1;
					pend_d    = 1'b1;
				end else if (rsp.done) begin
					pend_d = 1'b0;
					case (state_q)
						B_DIV_MX:  state_d = B_DIV_MY;
						B_DIV_MY:  state_d = B_DIV_EXX;
						B_DIV_EXX: state_d = B_DIV_EYY;
						B_DIV_EYY: state_d = B_DIV_EXY;
						B_DIV_EXY: state_d = B_MUL;
						B_RATIO1:  state_d = B_RATIO2;
						B_RATIO2:  state_d = B_PROD;
						default:   state_d = B_OUT;
					endcase
				end
			end
			B_MUL:  state_d = B_PREP;
			B_PREP: state_d = B_RATIO1;
			B_PROD: state_d = B_ACC;
			B_ACC:  state_d = last_q ? B_MEAN : B_OUT;
			B_OUT: begin
				if (!res_full) begin
					res_push = 1'b1;
					state_d  = B_IDLE;
				end
			end
			default: state_d = B_IDLE;
		endcase
	end

	// running image totals
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_q <= '0;
			tally_q <= '0;
		end else if (state_q == B_ACC) begin
			total_q <= total_nx;
			tally_q <= tally_nx;
		end else if (state_q == B_OUT && !res_full && last_q) begin
			total_q <= '0;
			tally_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			B_IDLE: begin
				if (!snap_empty) begin
					{last_q, n_q, ssrc_q, scmp_q, qsrc_q, qcmp_q, qx_q} <= snap_data;
				end
			end
			B_DIV_MX:  if (pend_q && rsp.done) mx_q  <= rsp.quo[15:0];
			B_DIV_MY:  if (pend_q && rsp.done) my_q  <= rsp.quo[15:0];
			B_DIV_EXX: if (pend_q && rsp.done) exx_q <= rsp.quo[23:0];
			B_DIV_EYY: if (pend_q && rsp.done) eyy_q <= rsp.quo[23:0];
			B_DIV_EXY: if (pend_q && rsp.done) exy_q <= rsp.quo[23:0];
			B_MUL: begin
				pxx_q <= mx_q * mx_q;
				pyy_q <= my_q * my_q;
				pxy_q <= mx_q * my_q;
			end
			B_PREP: begin
				num1_q    <= num1_d;
				den1_q    <= den1_d;
				den2_q    <= den2_d;
				num2mag_q <= num2mag_d;
				num2neg_q <= num2_d[26];
			end
			B_RATIO1: begin
				if (skip1) begin
					r1_q <= ONE_Q16;
				end else if (pend_q && rsp.done) begin
					r1_q <= {1'b0, rsp.quo[15:0]};
				end
			end
			B_RATIO2: begin
				if (skip2) begin
					r2_q    <= ONE_Q16;
					r2neg_q <= (den2_q != '0) && num2neg_q;
				end else if (pend_q && rsp.done) begin
					r2_q    <= {1'b0, rsp.quo[15:0]};
					r2neg_q <= num2neg_q;
				end
			end
			B_PROD: begin
				mag_q <= rounded[32:16];
				neg_q <= r2neg_q && (rounded[32:16] != '0);
			end
			B_ACC: begin
				score_q   <= neg_q ? (SCORE_W'(0) - SCORE_W'(mag_q)) : SCORE_W'(mag_q);
				img_q     <= '0;
				tot_neg_q <= total_nx[TOTAL_W-1];
				tot_mag_q <= total_nx[TOTAL_W-1] ? (TOTAL_W'(0) - total_nx) : total_nx;
			end
			B_MEAN: begin
				if (tally_q != '0 && pend_q && rsp.done) begin
					img_q <= tot_neg_q ? (SCORE_W'(0) - rsp.quo[SCORE_W-1:0])
						: rsp.quo[SCORE_W-1:0];
				end
			end
			default: begin
			end
		endcase
	end
endmodule

>>> dv/block_ssim_engine_unit_test.sv
// Self-checking test of the block SSIM engine: drives pixel beats, predicts block and image
// scores with a fixed-point model of its own, and checks every result beat in order.
// Depends on bssim_pkg and the block_ssim_engine_unit RTL.
module block_ssim_engine_unit_test;
	timeunit 1ns;
	timeprecision 1ps;
	import bssim_pkg::*;

	localparam int MAX_SIDE = 16;
	localparam int TALLY_W = 20;

	typedef struct packed {
		logic signed [SCORE_W-1:0] block_score;
		logic signed [SCORE_W-1:0] image_score;
		logic                      image_done;
	} score_beat_t;

	typedef enum int {
		PAT_NOISE,
		PAT_NEAR,
		PAT_FLAT,
		PAT_INVERT
	} pattern_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0;
	logic full;
	logic [7:0] src_pixel = '0;
	logic [7:0] cmp_pixel = '0;
	logic final_block = 1'b0;
	logic empty;
	logic pop = 1'b0;
	logic signed [SCORE_W-1:0] block_score;
	logic signed [SCORE_W-1:0] image_score;
	logic image_done;
	logic wr_en = 1'b0;
	logic [INDEX_W-1:0] wr_index = '0;
	logic [STAB_W-1:0] wr_data = '0;

	block_ssim_engine_unit #(.MAX_BLOCK_SIDE(MAX_SIDE), .BLOCK_COUNT_BITS(TALLY_W)) dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// predictor state
	logic [SIDE_REG_W-1:0] side_reg = SIDE_RESET;
	logic [STAB_W-1:0] c1_reg = LUMA_RESET;
	logic [STAB_W-1:0] c2_reg = CONTR_RESET;
	logic [8:0] pix_cnt = '0;
	longint unsigned acc_x, acc_y, acc_xx, acc_yy, acc_xy;
	logic [TOTAL_W-1:0] score_sum = '0;
	logic [TALLY_W-1:0] blocks_seen = '0;
	score_beat_t score_queue[$];
	int errors = 0;
	int results_seen = 0;
	bit stall_on = 1'b1;
	bit hold_off = 1'b0;
	bit quiet = 1'b0;

	function automatic longint ssim_of_block(longint n);
		longint mx, my, exx, eyy, exy, vx, vy, cv, num1, den1, num2, den2, r1, r2, p;
		bit neg;
		mx = (acc_x << 8) / n;
		my = (acc_y << 8) / n;
		exx = (acc_xx << 8) / n;
		eyy = (acc_yy << 8) / n;
		exy = (acc_xy << 8) / n;
		vx = exx - (mx * mx) / 256;
		vy = eyy - (my * my) / 256;
		cv = exy - (mx * my) / 256;
		if (vx < 0) vx = 0;
		if (vy < 0) vy = 0;
		num1 = (2 * mx * my) / 256 + longint'(c1_reg);
		den1 = (mx * mx + my * my) / 256 + longint'(c1_reg);
		if (den1 == 0) r1 = 65536;
		else begin
			r1 = (num1 << 16) / den1;
			if (r1 > 65536) r1 = 65536;
		end
		num2 = 2 * cv + longint'(c2_reg);
		den2 = vx + vy + longint'(c2_reg);
		neg = 1'b0;
		if (den2 == 0) r2 = 65536;
		else begin
			neg = num2 < 0;
			r2 = ((neg ? -num2 : num2) << 16) / den2;
			if (r2 > 65536) r2 = 65536;
		end
		p = (r1 * r2 + 32768) >>> 16;
		return neg ? -p : p;
	endfunction

	task automatic predict_pixel(logic [7:0] x, logic [7:0] y, logic fin);
		int side;
		longint s;
		longint tot;
		longint q;
		score_beat_t b;
		side = side_reg < 2 ? 2 : (side_reg > MAX_SIDE ? MAX_SIDE : side_reg);
		pix_cnt = pix_cnt + 9'd1;
		acc_x += x;
		acc_y += y;
		acc_xx += x * x;
		acc_yy += y * y;
		acc_xy += x * y;
		if (pix_cnt < side * side) return;
		s = ssim_of_block(pix_cnt);
		score_sum = score_sum + TOTAL_W'(s);
		blocks_seen = blocks_seen + TALLY_W'(1);
		b.block_score = SCORE_W'(s);
		b.image_score = '0;
		b.image_done = fin;
		if (fin) begin
			tot = longint'($signed(score_sum));
			if (blocks_seen != 0) begin
				q = (tot < 0 ? -tot : tot) / longint'(blocks_seen);
				b.image_score = SCORE_W'(tot < 0 ? -q : q);
			end
			score_sum = '0;
			blocks_seen = '0;
		end
		score_queue.push_back(b);
		pix_cnt = '0;
		{acc_x, acc_y, acc_xx, acc_yy, acc_xy} = '0;
	endtask

	task automatic send_pixel(logic [7:0] x, logic [7:0] y, logic fin);
		while (!quiet && stall_on && $urandom_range(99) < 18) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		src_pixel <= x;
		cmp_pixel <= y;
		final_block <= fin;
		do @(posedge clk); while (full);
		predict_pixel(x, y, fin);
	endtask

	task automatic send_block(int n, pattern_t mode, logic fin);
		int base;
		logic [7:0] x, y;
		base = $urandom_range(255);
		for (int i = 0; i < n; i++) begin
			case (mode)
				PAT_NOISE: begin x = 8'($urandom); y = 8'($urandom); end
				PAT_NEAR: begin x = 8'(base + $urandom_range(8)); y = 8'(x + $urandom_range(6) - 3); end
				PAT_FLAT: begin x = 8'(base); y = 8'(base); end
				default: begin x = 8'($urandom); y = ~x; end
			endcase
			send_pixel(x, y, fin);
		end
	endtask

	task automatic settle();
		push <= 1'b0;
		while (score_queue.size() != 0) @(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	task automatic write_reg(logic [INDEX_W-1:0] idx, logic [STAB_W-1:0] val);
		wr_en <= 1'b1;
		wr_index <= idx;
		wr_data <= val;
		@(posedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_BLOCK_SIDE: side_reg = val[SIDE_REG_W-1:0];
			REG_LUMA_STAB: c1_reg = val;
			default: c2_reg = val;
		endcase
	endtask

	function automatic int side_now();
		return side_reg < 2 ? 2 : (side_reg > MAX_SIDE ? MAX_SIDE : side_reg);
	endfunction

	// result checker
	always @(posedge clk) begin
		score_beat_t want;
		if (pop && !empty) begin
			results_seen++;
			if (score_queue.size() == 0) begin
				$error("result beat with nothing expected");
				errors++;
			end else begin
				want = score_queue.pop_front();
				if (block_score !== want.block_score) begin
					$error("block_score exp %0d got %0d", want.block_score, block_score);
					errors++;
				end
				if (image_score !== want.image_score) begin
					$error("image_score exp %0d got %0d", want.image_score, image_score);
					errors++;
				end
				if (image_done !== want.image_done) begin
					$error("image_done exp %0d got %0d", want.image_done, image_done);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if (hold_off) pop <= 1'b0;
		else if (!quiet && stall_on) pop <= $urandom_range(99) >= 18;
		else pop <= 1'b1;
	end

	task automatic test_extremes();
		write_reg(REG_BLOCK_SIDE, 24'd2);
		send_block(4, PAT_FLAT, 1'b0);
		for (int i = 0; i < 4; i++) send_pixel(8'hff, 8'hff, 1'b0);
		for (int i = 0; i < 4; i++) send_pixel(8'h00, 8'hff, 1'b0);
		send_block(4, PAT_INVERT, 1'b0);
		send_block(4, PAT_NOISE, 1'b1);
		settle();
	endtask

	task automatic test_side_clamp();
		write_reg(REG_BLOCK_SIDE, 24'd0);
		send_block(4, PAT_NEAR, 1'b1);
		settle();
		write_reg(REG_BLOCK_SIDE, 24'd31);
		send_block(256, PAT_NOISE, 1'b1);
		settle();
		write_reg(REG_BLOCK_SIDE, 24'd16);
		send_block(256, PAT_NEAR, 1'b0);
		settle();
		// smaller side after a full-size block, closing the image
		write_reg(REG_BLOCK_SIDE, 24'd3);
		send_block(9, PAT_NEAR, 1'b1);
		settle();
	endtask

	task automatic test_zero_stabilizers();
		write_reg(REG_LUMA_STAB, 24'd0);
		write_reg(REG_CONTR_STAB, 24'd0);
		write_reg(REG_BLOCK_SIDE, 24'd2);
		for (int i = 0; i < 4; i++) send_pixel(8'h00, 8'h00, 1'b0);
		send_block(4, PAT_FLAT, 1'b0);
		send_block(4, PAT_INVERT, 1'b1);
		settle();
		write_reg(REG_LUMA_STAB, 24'hffffff);
		write_reg(REG_CONTR_STAB, 24'hffffff);
		send_block(4, PAT_NOISE, 1'b1);
		settle();
	endtask

	task automatic test_backpressure();
		write_reg(REG_LUMA_STAB, LUMA_RESET);
		write_reg(REG_CONTR_STAB, CONTR_RESET);
		write_reg(REG_BLOCK_SIDE, 24'd2);
		hold_off = 1'b1;
		fork
			begin
				repeat (3000) @(posedge clk);
				hold_off = 1'b0;
			end
			repeat (12) send_block(4, PAT_NOISE, 1'b0);
		join
		send_block(4, PAT_NEAR, 1'b1);
		settle();
	endtask

	task automatic test_random();
		int sent;
		int n;
		int sides[5] = '{2, 3, 4, 5, 8};
		sent = 0;
		while (sent < 800) begin
			write_reg(REG_BLOCK_SIDE, 24'(sides[$urandom_range(4)]));
			if ($urandom_range(3) == 0) write_reg(REG_LUMA_STAB, 24'($urandom_range(3000)));
			if ($urandom_range(3) == 0) write_reg(REG_CONTR_STAB, 24'($urandom_range(30000)));
			quiet = $urandom_range(4) == 0;
			for (int b = $urandom_range(1, 6); b > 0; b--) begin
				n = side_now() * side_now();
				send_block(n, pattern_t'($urandom_range(3)), b == 1);
				sent += n;
			end
			settle();
		end
		quiet = 1'b0;
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_extremes();
		test_side_clamp();
		test_zero_stabilizers();
		test_backpressure();
		test_random();
		settle();
		if (errors == 0) $display("TEST PASSED");
		else $display("TEST FAILED");
		$finish;
	end

	initial begin
		#20ms;
		$display("TEST FAILED");
		$finish;
	end
endmodule
